/* hw/rtl/timeline_semaphore_waiter_table_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the timeline semaphore waiter table
// Clocked property wrappers used by the waiter table top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef TIMELINE_SEMAPHORE_WAITER_TABLE_ASSERT_SVH
`define TIMELINE_SEMAPHORE_WAITER_TABLE_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define TSW_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define TSW_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error(msg);

`endif

/* hw/rtl/tsw_pkg.sv */
// ----------------------------------------------------------------------------
// Timeline semaphore waiter table package
// Shared types, field widths and command codes.
// ----------------------------------------------------------------------------
package tsw_pkg;

    localparam int WAITER_SLOTS_DEF = 16;
    localparam int VAL_W  = 64;
    localparam int TAG_W  = 8;
    localparam int CODE_W = 5;
    localparam int OP_W   = 4;
    localparam int STAT_W = 2;
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 152;

    // Command codes
    localparam logic [OP_W-1:0] OP_SIGNAL          = 4'd0;
    localparam logic [OP_W-1:0] OP_SIGNAL_UNTAINTED = 4'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE         = 4'd2;
    localparam logic [OP_W-1:0] OP_DISPATCH        = 4'd3;
    localparam logic [OP_W-1:0] OP_ACQUIRE         = 4'd4;
    localparam logic [OP_W-1:0] OP_CANCEL          = 4'd5;
    localparam logic [OP_W-1:0] OP_FAIL            = 4'd6;
    localparam logic [OP_W-1:0] OP_DISPATCH_FAILED = 4'd7;
    localparam logic [OP_W-1:0] OP_MARK_TAINTED    = 4'd8;
    localparam logic [OP_W-1:0] OP_QUERY_TAINTED   = 4'd9;

    // Reply status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_PAST    = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [VAL_W-1:0] minimum;
    } entry_t;

    typedef struct packed {
        logic              is_fire;
        logic [TAG_W-1:0]  fired_tag;
        logic [CODE_W-1:0] fired_code;
        logic [STAT_W-1:0] reply_status;
        logic [VAL_W-1:0]  timeline_now;
        logic [VAL_W-1:0]  watermark_now;
        logic [CODE_W-1:0] failed_code;
        logic              is_tainted;
        logic              last;
    } result_t;

endpackage

/* hw/rtl/tsw_waiter_mem.sv */
// ----------------------------------------------------------------------------
// Waiter memory
// One write port and one registered read port over the waiter entries.
// ----------------------------------------------------------------------------
module tsw_waiter_mem #(
    parameter int WAITER_SLOTS = tsw_pkg::WAITER_SLOTS_DEF,
    parameter int IDX_W = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  tsw_pkg::entry_t     wr_data,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    output tsw_pkg::entry_t     rd_data
);

    tsw_pkg::entry_t mem [WAITER_SLOTS];
    tsw_pkg::entry_t rd_data_reg;

    // Write entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read entry, hold data between reads
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/tsw_out_reg.sv */
// ----------------------------------------------------------------------------
// Result output register
// Holds one result beat and packs it onto the master stream.
// ----------------------------------------------------------------------------
module tsw_out_reg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  tsw_pkg::result_t              item,
    output logic                          free,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // fired_tag, fired_code, reply_status, timeline_now, watermark_now,
    // failed_code, is_tainted, zero fill
    output logic [tsw_pkg::M_DATA_W-1:0]  m_tdata,
    // is_fire
    output logic                          m_tuser,
    output logic                          m_tlast
);

    logic             valid_reg;
    tsw_pkg::result_t item_reg;

    assign free = !valid_reg || m_tready;

    // Hold beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
        if (load && free) begin
            item_reg <= item;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = item_reg.is_fire;
    assign m_tlast  = item_reg.last;
    assign m_tdata  = {3'b000, item_reg.is_tainted, item_reg.failed_code,
                       item_reg.watermark_now, item_reg.timeline_now,
                       item_reg.reply_status, item_reg.fired_code,
                       item_reg.fired_tag};

endmodule

/* hw/rtl/timeline_semaphore_waiter_table.sv */
// ----------------------------------------------------------------------------
// Timeline semaphore waiter table
// Timeline, watermark, failure latch and a packed table of waiters.
// ----------------------------------------------------------------------------
// One command is taken at a time. Signal, dispatch, fail and dispatch_failed walk
// the table newest entry first at one slot per cycle, stalling while a fired
// notice waits for the result stream, emitting fired notices, then walk it again
// oldest first to pack the survivors. Cancel searches down from the newest entry
// and packs up from the hit. The waiter memory serves one read per cycle, and a
// stalled result stream holds the walk. The reply beat (tlast) is always the
// last beat of a command. Writing cfg_wr_data reloads timeline and watermark
// and must happen only while the block is idle.
module timeline_semaphore_waiter_table #(
    parameter int WAITER_SLOTS = tsw_pkg::WAITER_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [tsw_pkg::VAL_W-1:0]     cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // operation, value, waiter_tag, failure_code, zero fill
    input  logic [tsw_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // fired_tag, fired_code, reply_status, timeline_now, watermark_now,
    // failed_code, is_tainted, zero fill
    output logic [tsw_pkg::M_DATA_W-1:0]  m_tdata,
    // is_fire
    output logic                          m_tuser,
    output logic                          m_tlast
);

    `include "timeline_semaphore_waiter_table_assert.svh"

    localparam int IDX_W = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
    localparam int CNT_W = $clog2(WAITER_SLOTS + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(WAITER_SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE, ST_FIRE, ST_SCAN, ST_PACK, ST_ONE_FIRE, ST_REPLY
    } state_t;

    state_t state_reg, state_next;
    logic [tsw_pkg::VAL_W-1:0]  tl_reg, tl_next, mark_reg, mark_next, val_reg, val_next;
    logic [tsw_pkg::CODE_W-1:0] fail_reg, fail_next, fcode_reg, fcode_next;
    logic [tsw_pkg::TAG_W-1:0]  tag_reg, tag_next;
    logic [tsw_pkg::STAT_W-1:0] status_reg, status_next;
    logic                       taint_reg, taint_next, all_reg, all_next;
    logic                       cancel_reg, cancel_next;
    logic [CNT_W-1:0]           count_reg, count_next, k_reg, k_next;
    logic [IDX_W-1:0]           idx_reg, idx_next, hit_reg, hit_next;

    logic                       accept, out_free, out_load;
    tsw_pkg::result_t           out_item;
    logic                       mem_wr_en, mem_rd_en;
    logic [IDX_W-1:0]           mem_wr_addr, mem_rd_addr;
    tsw_pkg::entry_t            mem_wr_data, rd_entry;

    logic [tsw_pkg::OP_W-1:0]   in_op;
    logic [tsw_pkg::VAL_W-1:0]  in_val;
    logic [tsw_pkg::TAG_W-1:0]  in_tag;
    logic [tsw_pkg::CODE_W-1:0] in_code;
    logic                       sweep_gone, pack_gone, at_top;

    assign in_op   = s_tdata[3:0];
    assign in_val  = s_tdata[67:4];
    assign in_tag  = s_tdata[75:68];
    assign in_code = s_tdata[80:76];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign sweep_gone = all_reg || (rd_entry.minimum <= val_reg);
    assign pack_gone  = cancel_reg ? (idx_reg == hit_reg) : sweep_gone;
    assign at_top     = (CNT_W'(idx_reg) + 1'b1) == count_reg;

    tsw_waiter_mem #(.WAITER_SLOTS(WAITER_SLOTS), .IDX_W(IDX_W)) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (rd_entry)
    );

    tsw_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .item     (out_item),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Decode commands, walk the table, build result beats
    always_comb begin
        state_next  = state_reg;
        tl_next     = tl_reg;
        mark_next   = mark_reg;
        val_next    = val_reg;
        fail_next   = fail_reg;
        fcode_next  = fcode_reg;
        tag_next    = tag_reg;
        status_next = status_reg;
        taint_next  = taint_reg;
        all_next    = all_reg;
        cancel_next = cancel_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        idx_next    = idx_reg;
        hit_next    = hit_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = k_reg[IDX_W-1:0];
        mem_wr_data = rd_entry;
        mem_rd_en   = 1'b0;
        mem_rd_addr = idx_reg;
        out_load    = 1'b0;
        out_item.is_fire       = 1'b1;
        out_item.fired_tag     = rd_entry.tag;
        out_item.fired_code    = fcode_reg;
        out_item.reply_status  = tsw_pkg::ST_OK;
        out_item.timeline_now  = tl_reg;
        out_item.watermark_now = mark_reg;
        out_item.failed_code   = fail_reg;
        out_item.is_tainted    = 1'b0;
        out_item.last          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    val_next    = in_val;
                    tag_next    = in_tag;
                    status_next = tsw_pkg::ST_OK;
                    taint_next  = 1'b0;
                    all_next    = 1'b0;
                    cancel_next = 1'b0;
                    fcode_next  = '0;
                    state_next  = ST_REPLY;
                    case (in_op)
                        tsw_pkg::OP_SIGNAL, tsw_pkg::OP_SIGNAL_UNTAINTED,
                        tsw_pkg::OP_ADVANCE: begin
                            if (in_val <= tl_reg) begin
                                status_next = tsw_pkg::ST_PAST;
                            end else begin
                                tl_next = in_val;
                                if (in_op == tsw_pkg::OP_SIGNAL_UNTAINTED &&
                                    in_val > mark_reg) begin
                                    mark_next = in_val;
                                end
                                if (in_op != tsw_pkg::OP_ADVANCE && count_reg != '0) begin
                                    state_next = ST_FIRE;
                                end
                            end
                        end
                        tsw_pkg::OP_DISPATCH: begin
                            if (count_reg != '0) state_next = ST_FIRE;
                        end
                        tsw_pkg::OP_ACQUIRE: begin
                            if (fail_reg != '0) begin
                                fcode_next = fail_reg;
                                state_next = ST_ONE_FIRE;
                            end else if (tl_reg >= in_val) begin
                                state_next = ST_ONE_FIRE;
                            end else if (count_reg >= FULL_COUNT) begin
                                status_next = tsw_pkg::ST_FULL;
                            end else begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = count_reg[IDX_W-1:0];
                                mem_wr_data.tag     = in_tag;
                                mem_wr_data.minimum = in_val;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        tsw_pkg::OP_CANCEL: begin
                            cancel_next = 1'b1;
                            if (count_reg != '0) state_next = ST_SCAN;
                        end
                        tsw_pkg::OP_FAIL: begin
                            if (in_code != '0 && fail_reg == '0) begin
                                fail_next  = in_code;
                                fcode_next = in_code;
                                all_next   = 1'b1;
                                if (count_reg != '0) state_next = ST_FIRE;
                            end
                        end
                        tsw_pkg::OP_DISPATCH_FAILED: begin
                            if (in_code != '0) begin
                                fcode_next = in_code;
                                all_next   = 1'b1;
                                if (count_reg != '0) state_next = ST_FIRE;
                            end
                        end
                        tsw_pkg::OP_MARK_TAINTED: begin
                            if (in_val < mark_reg) mark_next = in_val;
                        end
                        tsw_pkg::OP_QUERY_TAINTED: begin
                            taint_next = in_val > mark_reg;
                        end
                        default: begin
                        end
                    endcase
                    // Start the walk at the newest entry
                    if (state_next == ST_FIRE || state_next == ST_SCAN) begin
                        idx_next    = IDX_W'(count_reg - 1'b1);
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = idx_next;
                    end
                end
            end
            ST_FIRE: begin
                if (!sweep_gone || out_free) begin
                    out_load = sweep_gone;
                    if (idx_reg == '0) begin
                        state_next = ST_PACK;
                        k_next     = '0;
                    end else begin
                        idx_next = idx_reg - 1'b1;
                    end
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = (idx_reg == '0) ? idx_reg : idx_reg - 1'b1;
                end
            end
            ST_SCAN: begin
                if (rd_entry.tag == tag_reg) begin
                    hit_next    = idx_reg;
                    k_next      = CNT_W'(idx_reg);
                    state_next  = ST_PACK;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_reg;
                end else if (idx_reg == '0) begin
                    state_next = ST_REPLY;
                end else begin
                    idx_next    = idx_reg - 1'b1;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_next;
                end
            end
            ST_PACK: begin
                // Move survivors down over the removed entries
                if (!pack_gone) begin
                    mem_wr_en = 1'b1;
                    k_next    = k_reg + 1'b1;
                end
                if (at_top) begin
                    count_next = k_next;
                    state_next = ST_REPLY;
                end else begin
                    idx_next    = idx_reg + 1'b1;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_next;
                end
            end
            ST_ONE_FIRE: begin
                out_item.fired_tag = tag_reg;
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_REPLY;
                end
            end
            ST_REPLY: begin
                out_item.is_fire      = 1'b0;
                out_item.fired_tag    = '0;
                out_item.fired_code   = '0;
                out_item.reply_status = status_reg;
                out_item.is_tainted   = taint_reg;
                out_item.last         = 1'b1;
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Reload timeline and watermark on a configuration write
        if (cfg_wr_en) begin
            tl_next   = cfg_wr_data;
            mark_next = cfg_wr_data;
        end
    end

    // Hold control state and command context
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tl_reg    <= '0;
            mark_reg  <= '0;
            fail_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            tl_reg    <= tl_next;
            mark_reg  <= mark_next;
            fail_reg  <= fail_next;
            count_reg <= count_next;
        end
        val_reg    <= val_next;
        fcode_reg  <= fcode_next;
        tag_reg    <= tag_next;
        status_reg <= status_next;
        taint_reg  <= taint_next;
        all_reg    <= all_next;
        cancel_reg <= cancel_next;
        k_reg      <= k_next;
        idx_reg    <= idx_next;
        hit_reg    <= hit_next;
    end

    `TSW_NEVER(a_count_bound, aclk, aresetn, count_reg > FULL_COUNT,
        "waiter count overflow")
    `TSW_ASSERT(a_walk_in_table, aclk, aresetn,
        (state_reg == ST_FIRE || state_reg == ST_PACK) |-> (CNT_W'(idx_reg) < count_reg),
        "walk index beyond table")
    `TSW_ASSERT(a_accept_busy, aclk, aresetn, accept |=> (state_reg != ST_IDLE),
        "command dropped without reply")
    `TSW_NEVER(a_pack_overrun, aclk, aresetn,
        state_reg == ST_PACK && k_reg > CNT_W'(idx_reg),
        "pack write ahead of read")

endmodule
